// ----- design/assert_macros.svh -----
// Assertion macros shared by the rotation matrix block.
// Implication checked in the same cycle, disabled while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define EZR_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed: same-cycle implication");

// Implication checked in the next cycle.
`define EZR_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- design/ezr_pkg.sv -----
// ----------------------------------------------------------------------------
// ezr_pkg
// Constants, widths and elaboration-time tables for the Euler ZYX rotation
// matrix pipeline.
// ----------------------------------------------------------------------------
package ezr_pkg;

	localparam int ANG_W             = 16;
	localparam int OUT_W             = 16;
	localparam int Q_FRAC            = 30;
	localparam int OUT_FRAC_BITS_DEF = 14;
	localparam int OUT_POS_MAX       = 32767;
	localparam int OUT_NEG_MAX       = 32768;

	localparam int FULL_UNITS      = 46080;
	localparam int HALF_TURN_UNITS = 23040;
	localparam int QUARTER_UNITS   = 11520;

	localparam int ARG_W  = 14;
	localparam int XQ_W   = 31;
	localparam int X2_W   = 32;
	localparam int T_W    = 31;
	localparam int TRIG_W = 32;

	localparam logic [63:0] PI_Q30   = 64'd3373259426;
	localparam logic [63:0] ONE_Q30  = 64'h0000_0000_4000_0000;
	localparam logic [63:0] HALF_Q30 = 64'h0000_0000_2000_0000;
	localparam logic [63:0] TWO32    = 64'h0000_0001_0000_0000;

	// split of the quarter-wave argument into a = 180*m + n
	localparam int DIV180       = 180;
	localparam int DIV180_MUL   = 23302;
	localparam int DIV180_MUL_W = 15;
	localparam int DIV180_SH    = 22;
	localparam int M_N          = QUARTER_UNITS / DIV180 + 1;
	localparam int M_W          = $clog2(M_N);
	localparam int N_W          = $clog2(DIV180);
	localparam int REM_W        = 15;
	localparam int RSUM_W       = 17;

	localparam int TAYLOR_N = 8;
	localparam int TDIV_W   = 9;

	localparam int QSIN_LAT = 5 + 3 * TAYLOR_N + 1;
	localparam int TRIG_LAT = 2 + QSIN_LAT + 1;
	localparam int MAT_LAT  = 4;
	localparam int EZR_LAT  = TRIG_LAT + MAT_LAT;

	typedef logic [31:0]          q32_m_t [M_N];
	typedef logic [REM_W-1:0]     rem_m_t [M_N];
	typedef logic [31:0]          q32_n_t [DIV180];
	typedef logic [REM_W-1:0]     rem_n_t [DIV180];
	typedef logic [TDIV_W-1:0]    tdiv_t  [TAYLOR_N];
	typedef logic [31:0]          trec_t  [TAYLOR_N];

	localparam tdiv_t TAYLOR_DIV = '{9'd272, 9'd210, 9'd156, 9'd110,
		9'd72, 9'd42, 9'd20, 9'd6};

	// floor(2^32 / d): quotient estimate is low by at most one
	localparam trec_t TAYLOR_REC = '{32'(TWO32 / 272), 32'(TWO32 / 210),
		32'(TWO32 / 156), 32'(TWO32 / 110), 32'(TWO32 / 72),
		32'(TWO32 / 42), 32'(TWO32 / 20), 32'(TWO32 / 6)};

	function automatic q32_m_t gen_mq();
		logic [63:0] prod;
		q32_m_t tab;
		for (int i = 0; i < M_N; i++) begin
			prod = 64'(i) * 64'(DIV180) * PI_Q30;
			tab[i] = 32'(prod / HALF_TURN_UNITS);
		end
		return tab;
	endfunction

	function automatic rem_m_t gen_mr();
		logic [63:0] prod;
		rem_m_t tab;
		for (int i = 0; i < M_N; i++) begin
			prod = 64'(i) * 64'(DIV180) * PI_Q30;
			tab[i] = REM_W'(prod % HALF_TURN_UNITS);
		end
		return tab;
	endfunction

	function automatic q32_n_t gen_nq();
		logic [63:0] prod;
		q32_n_t tab;
		for (int i = 0; i < DIV180; i++) begin
			prod = 64'(i) * PI_Q30;
			tab[i] = 32'(prod / HALF_TURN_UNITS);
		end
		return tab;
	endfunction

	function automatic rem_n_t gen_nr();
		logic [63:0] prod;
		rem_n_t tab;
		for (int i = 0; i < DIV180; i++) begin
			prod = 64'(i) * PI_Q30;
			tab[i] = REM_W'(prod % HALF_TURN_UNITS);
		end
		return tab;
	endfunction

	localparam q32_m_t MQ_TAB = gen_mq();
	localparam rem_m_t MR_TAB = gen_mr();
	localparam q32_n_t NQ_TAB = gen_nq();
	localparam rem_n_t NR_TAB = gen_nr();

endpackage

// ----- design/ezr_qsin.sv -----
// ----------------------------------------------------------------------------
// ezr_qsin
// Quarter-wave sine pipeline: angle units to radians, then an eight-term
// nested series, one multiply and one reciprocal divide per step.
// ----------------------------------------------------------------------------
module ezr_qsin (
	input  logic                       clk,
	input  logic [ezr_pkg::ARG_W-1:0]  arg,
	output logic [ezr_pkg::XQ_W-1:0]   sin_mag
);

	localparam int MUL_W = ezr_pkg::ARG_W + ezr_pkg::DIV180_MUL_W;
	localparam int NT    = ezr_pkg::TAYLOR_N;

	logic [MUL_W-1:0]          mprod;
	logic [ezr_pkg::ARG_W-1:0] ndiff;
	logic [ezr_pkg::M_W-1:0]   m_s1, m_s2;
	logic [ezr_pkg::ARG_W-1:0] a_s1;
	logic [ezr_pkg::N_W-1:0]   n_s2;
	logic [31:0]               xsum_s3;
	logic [ezr_pkg::RSUM_W-1:0] rsum_s3;
	logic [1:0]                rcarry;
	logic [ezr_pkg::XQ_W-1:0]  x_s4, x_s5, s_sf;
	logic [63:0]               sq;
	logic [ezr_pkg::X2_W-1:0]  x2_s5;
	logic [61:0]               fp;

	logic [ezr_pkg::X2_W-1:0]  it_x2 [NT+1];
	logic [ezr_pkg::XQ_W-1:0]  it_x  [NT+1];
	logic [ezr_pkg::T_W-1:0]   it_t  [NT+1];

	// m = a / 180 by reciprocal, exact over the quarter-wave range
	assign mprod = MUL_W'(arg) * MUL_W'(ezr_pkg::DIV180_MUL);
	assign ndiff = a_s1 - ezr_pkg::ARG_W'(ezr_pkg::DIV180) * ezr_pkg::ARG_W'(m_s1);

	always_comb begin
		if (rsum_s3 >= ezr_pkg::RSUM_W'(2 * ezr_pkg::HALF_TURN_UNITS))
			rcarry = 2'd2;
		else if (rsum_s3 >= ezr_pkg::RSUM_W'(ezr_pkg::HALF_TURN_UNITS))
			rcarry = 2'd1;
		else
			rcarry = 2'd0;
	end

	assign sq = 64'(x_s4) * 64'(x_s4) + ezr_pkg::HALF_Q30;

	always_ff @(posedge clk) begin
		m_s1    <= mprod[ezr_pkg::DIV180_SH +: ezr_pkg::M_W];
		a_s1    <= arg;
		n_s2    <= ndiff[ezr_pkg::N_W-1:0];
		m_s2    <= m_s1;
		xsum_s3 <= ezr_pkg::MQ_TAB[m_s2] + ezr_pkg::NQ_TAB[n_s2];
		rsum_s3 <= ezr_pkg::RSUM_W'(ezr_pkg::MR_TAB[m_s2])
			+ ezr_pkg::RSUM_W'(ezr_pkg::NR_TAB[n_s2])
			+ ezr_pkg::RSUM_W'(ezr_pkg::QUARTER_UNITS);
		x_s4    <= ezr_pkg::XQ_W'(xsum_s3 + 32'(rcarry));
		x2_s5   <= sq[ezr_pkg::Q_FRAC +: ezr_pkg::X2_W];
		x_s5    <= x_s4;
	end

	assign it_x2[0] = x2_s5;
	assign it_x[0]  = x_s5;
	assign it_t[0]  = ezr_pkg::T_W'(ezr_pkg::ONE_Q30);

	for (genvar i = 0; i < NT; i++) begin : g_itr
		logic [62:0] pt;
		logic [63:0] qk;
		logic [40:0] qd, rem;
		logic [31:0] y_sa, y_sb, q0_sb;
		logic [ezr_pkg::X2_W-1:0] x2_sa, x2_sb, x2_sc;
		logic [ezr_pkg::XQ_W-1:0] x_sa, x_sb, x_sc;
		logic [ezr_pkg::T_W-1:0]  t_sc;

		assign pt  = 63'(it_x2[i]) * 63'(it_t[i]) + 63'(ezr_pkg::HALF_Q30);
		assign qk  = 64'(y_sa) * 64'(ezr_pkg::TAYLOR_REC[i]);
		assign qd  = 41'(q0_sb) * 41'(ezr_pkg::TAYLOR_DIV[i]);
		assign rem = 41'(y_sb) - qd;

		always_ff @(posedge clk) begin
			y_sa  <= 32'(pt >> ezr_pkg::Q_FRAC) + 32'(ezr_pkg::TAYLOR_DIV[i] >> 1);
			x2_sa <= it_x2[i];
			x_sa  <= it_x[i];
			q0_sb <= qk[63:32];
			y_sb  <= y_sa;
			x2_sb <= x2_sa;
			x_sb  <= x_sa;
			// estimate may be one short: add it back when the remainder allows
			t_sc  <= ezr_pkg::T_W'(ezr_pkg::ONE_Q30) - ezr_pkg::T_W'(q0_sb)
				- ezr_pkg::T_W'(rem >= 41'(ezr_pkg::TAYLOR_DIV[i]));
			x2_sc <= x2_sb;
			x_sc  <= x_sb;
		end

		assign it_x2[i+1] = x2_sc;
		assign it_x[i+1]  = x_sc;
		assign it_t[i+1]  = t_sc;
	end

	assign fp = 62'(it_x[NT]) * 62'(it_t[NT]) + 62'(ezr_pkg::HALF_Q30);

	always_ff @(posedge clk) begin
		s_sf <= fp[ezr_pkg::Q_FRAC +: ezr_pkg::XQ_W];
	end

	assign sin_mag = s_sf;

endmodule

// ----- design/ezr_trig.sv -----
// ----------------------------------------------------------------------------
// ezr_trig
// Angle reduction, quadrant folding and six quarter-wave sine pipelines
// giving sine and cosine of yaw, pitch and roll in signed Q30.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ezr_trig (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               vld_in,
	input  logic signed [ezr_pkg::ANG_W-1:0]   ang [3],
	output logic                               vld_out,
	output logic signed [ezr_pkg::TRIG_W-1:0]  sn [3],
	output logic signed [ezr_pkg::TRIG_W-1:0]  cs [3]
);

	localparam int LAT = ezr_pkg::QSIN_LAT;
	localparam int NP  = 6;

	logic [15:0]               ph_d  [NP];
	logic [15:0]               ph_s1 [NP];
	logic [ezr_pkg::ARG_W-1:0] a_d   [NP];
	logic [ezr_pkg::ARG_W-1:0] a_s2  [NP];
	logic [NP-1:0]             neg_d, neg_s2;
	logic [NP-1:0]             neg_dly [LAT];
	logic [LAT-1:0]            vld_dly;
	logic                      vld_s1, vld_s2, vld_s3;
	logic [ezr_pkg::XQ_W-1:0]  mag [NP];
	logic signed [ezr_pkg::TRIG_W-1:0] val_s3 [NP];
	logic                      arg_ok;

	// even paths carry sine, odd paths cosine (angle plus a quarter turn)
	always_comb begin
		logic [15:0] v;
		logic [16:0] w;
		for (int k = 0; k < 3; k++) begin
			v = ang[k][ezr_pkg::ANG_W-1] ? 16'(ang[k]) + 16'(ezr_pkg::FULL_UNITS)
				: 16'(ang[k]);
			w = 17'(v) + 17'(ezr_pkg::QUARTER_UNITS);
			ph_d[2*k]   = v;
			ph_d[2*k+1] = (w >= 17'(ezr_pkg::FULL_UNITS))
				? 16'(w - 17'(ezr_pkg::FULL_UNITS)) : w[15:0];
		end
	end

	always_comb begin
		logic [1:0]  q;
		logic [15:0] r;
		for (int j = 0; j < NP; j++) begin
			if (ph_s1[j] >= 16'(3 * ezr_pkg::QUARTER_UNITS))
				q = 2'd3;
			else if (ph_s1[j] >= 16'(2 * ezr_pkg::QUARTER_UNITS))
				q = 2'd2;
			else if (ph_s1[j] >= 16'(ezr_pkg::QUARTER_UNITS))
				q = 2'd1;
			else
				q = 2'd0;
			r = ph_s1[j] - 16'(q) * 16'(ezr_pkg::QUARTER_UNITS);
			// odd quadrants run the quarter wave backwards
			a_d[j]   = q[0] ? ezr_pkg::ARG_W'(ezr_pkg::QUARTER_UNITS) - r[ezr_pkg::ARG_W-1:0]
				: r[ezr_pkg::ARG_W-1:0];
			neg_d[j] = q[1];
		end
	end

	always_ff @(posedge clk) begin
		ph_s1      <= ph_d;
		a_s2       <= a_d;
		neg_s2     <= neg_d;
		neg_dly[0] <= neg_s2;
		for (int d = 1; d < LAT; d++)
			neg_dly[d] <= neg_dly[d-1];
		for (int j = 0; j < NP; j++)
			val_s3[j] <= neg_dly[LAT-1][j] ? -ezr_pkg::TRIG_W'(mag[j])
				: ezr_pkg::TRIG_W'(mag[j]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_dly <= '0;
			vld_s3  <= 1'b0;
		end else begin
			vld_s1  <= vld_in;
			vld_s2  <= vld_s1;
			vld_dly <= {vld_dly[LAT-2:0], vld_s2};
			vld_s3  <= vld_dly[LAT-1];
		end
	end

	for (genvar j = 0; j < NP; j++) begin : g_path
		ezr_qsin u_qsin (
			.clk     (clk),
			.arg     (a_s2[j]),
			.sin_mag (mag[j])
		);
	end

	for (genvar k = 0; k < 3; k++) begin : g_out
		assign sn[k] = val_s3[2*k];
		assign cs[k] = val_s3[2*k+1];
	end

	assign vld_out = vld_s3;

	always_comb begin
		arg_ok = 1'b1;
		for (int j = 0; j < NP; j++)
			if (a_s2[j] > ezr_pkg::ARG_W'(ezr_pkg::QUARTER_UNITS))
				arg_ok = 1'b0;
	end

	`EZR_ASSERT_NEXT(a_arg_range, clk, arst_n, vld_s1, arg_ok)

endmodule

// ----- design/ezr_matrix.sv -----
// ----------------------------------------------------------------------------
// ezr_matrix
// Forms the nine elements of Rz*Ry*Rx from sines and cosines, rounds them to
// the output format and saturates to 16 bits.
// ----------------------------------------------------------------------------
module ezr_matrix #(
	parameter int OUT_FRAC_BITS = ezr_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               vld_in,
	input  logic signed [ezr_pkg::TRIG_W-1:0]  sn [3],
	input  logic signed [ezr_pkg::TRIG_W-1:0]  cs [3],
	output logic                               vld_out,
	output logic signed [ezr_pkg::OUT_W-1:0]   r [9]
);

	localparam int          SH  = ezr_pkg::Q_FRAC - OUT_FRAC_BITS;
	localparam logic [33:0] RND = (34'(1) << SH) >> 1;

	function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic [31:0] ma, mb, m;
		logic [63:0] pr;
		ma = a[31] ? 32'(-a) : 32'(a);
		mb = b[31] ? 32'(-b) : 32'(b);
		pr = 64'(ma) * 64'(mb) + ezr_pkg::HALF_Q30;
		m  = pr[ezr_pkg::Q_FRAC +: 32];
		return (a[31] ^ b[31]) ? -signed'(m) : signed'(m);
	endfunction

	function automatic logic signed [15:0] to_out(input logic signed [32:0] v);
		logic [32:0] mag;
		logic [33:0] m;
		logic signed [15:0] res;
		mag = v[32] ? 33'(-v) : 33'(v);
		m   = (34'(mag) + RND) >> SH;
		if (v[32])
			res = (m > 34'(ezr_pkg::OUT_NEG_MAX)) ? 16'sh8000 : 16'(34'(0) - m);
		else
			res = (m > 34'(ezr_pkg::OUT_POS_MAX)) ? 16'sh7fff : 16'(m);
		return res;
	endfunction

	// index 0 yaw (z), 1 pitch (y), 2 roll (x)
	logic signed [31:0] czsy_s1, szsy_s1, czcy_s1, szcx_s1, szsx_s1, szcy_s1;
	logic signed [31:0] czcx_s1, czsx_s1, cysx_s1, cycx_s1, sx_s1, cx_s1, sy_s1;
	logic signed [31:0] p01_s2, p02_s2, p11_s2, p12_s2;
	logic signed [31:0] szcx_s2, szsx_s2, czcx_s2, czsx_s2;
	logic signed [31:0] czcy_s2, szcy_s2, cysx_s2, cycx_s2, sy_s2;
	logic signed [32:0] e_s3 [9];
	logic signed [ezr_pkg::OUT_W-1:0] r_s4 [9];
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	always_ff @(posedge clk) begin
		czsy_s1 <= mulq(cs[0], sn[1]);
		szsy_s1 <= mulq(sn[0], sn[1]);
		czcy_s1 <= mulq(cs[0], cs[1]);
		szcx_s1 <= mulq(sn[0], cs[2]);
		szsx_s1 <= mulq(sn[0], sn[2]);
		szcy_s1 <= mulq(sn[0], cs[1]);
		czcx_s1 <= mulq(cs[0], cs[2]);
		czsx_s1 <= mulq(cs[0], sn[2]);
		cysx_s1 <= mulq(cs[1], sn[2]);
		cycx_s1 <= mulq(cs[1], cs[2]);
		sx_s1   <= sn[2];
		cx_s1   <= cs[2];
		sy_s1   <= sn[1];

		// triple products, left to right
		p01_s2  <= mulq(czsy_s1, sx_s1);
		p02_s2  <= mulq(czsy_s1, cx_s1);
		p11_s2  <= mulq(szsy_s1, sx_s1);
		p12_s2  <= mulq(szsy_s1, cx_s1);
		szcx_s2 <= szcx_s1;
		szsx_s2 <= szsx_s1;
		czcx_s2 <= czcx_s1;
		czsx_s2 <= czsx_s1;
		czcy_s2 <= czcy_s1;
		szcy_s2 <= szcy_s1;
		cysx_s2 <= cysx_s1;
		cycx_s2 <= cycx_s1;
		sy_s2   <= sy_s1;

		e_s3[0] <= 33'(czcy_s2);
		e_s3[1] <= 33'(p01_s2) - 33'(szcx_s2);
		e_s3[2] <= 33'(p02_s2) + 33'(szsx_s2);
		e_s3[3] <= 33'(szcy_s2);
		e_s3[4] <= 33'(p11_s2) + 33'(czcx_s2);
		e_s3[5] <= 33'(p12_s2) - 33'(czsx_s2);
		e_s3[6] <= -33'(sy_s2);
		e_s3[7] <= 33'(cysx_s2);
		e_s3[8] <= 33'(cycx_s2);

		for (int i = 0; i < 9; i++)
			r_s4[i] <= to_out(e_s3[i]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign vld_out = vld_s4;
	assign r       = r_s4;

endmodule

// ----- design/euler_zyx_rotation_matrix.sv -----
// ----------------------------------------------------------------------------
// euler_zyx_rotation_matrix
// Yaw, pitch and roll in 1/128 degree units to the nine elements of R = Rz*Ry*Rx.
// A start beat passes the trig pipeline, then the matrix pipeline, to the done strobe.
// Throughput: one beat per cycle; busy is held low, the pipeline never stalls.
// The depth is set by the eight-step series of the sine pipeline, three
// stages per step. Reset clears the valid bits only; the datapath holds none.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module euler_zyx_rotation_matrix #(
	parameter int OUT_FRAC_BITS = ezr_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [ezr_pkg::ANG_W-1:0]  yaw_deg,
	input  logic signed [ezr_pkg::ANG_W-1:0]  pitch_deg,
	input  logic signed [ezr_pkg::ANG_W-1:0]  roll_deg,
	output logic                              done,
	output logic signed [ezr_pkg::OUT_W-1:0]  r00,
	output logic signed [ezr_pkg::OUT_W-1:0]  r01,
	output logic signed [ezr_pkg::OUT_W-1:0]  r02,
	output logic signed [ezr_pkg::OUT_W-1:0]  r10,
	output logic signed [ezr_pkg::OUT_W-1:0]  r11,
	output logic signed [ezr_pkg::OUT_W-1:0]  r12,
	output logic signed [ezr_pkg::OUT_W-1:0]  r20,
	output logic signed [ezr_pkg::OUT_W-1:0]  r21,
	output logic signed [ezr_pkg::OUT_W-1:0]  r22
);

	localparam int LAT = ezr_pkg::EZR_LAT;

	logic signed [ezr_pkg::ANG_W-1:0]  ang [3];
	logic signed [ezr_pkg::TRIG_W-1:0] sn  [3];
	logic signed [ezr_pkg::TRIG_W-1:0] cs  [3];
	logic signed [ezr_pkg::OUT_W-1:0]  rm  [9];
	logic                              trig_vld;
	logic                              beat;

	assign busy   = 1'b0;
	assign beat   = start && !busy;
	assign ang[0] = yaw_deg;
	assign ang[1] = pitch_deg;
	assign ang[2] = roll_deg;

	ezr_trig u_trig (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (beat),
		.ang     (ang),
		.vld_out (trig_vld),
		.sn      (sn),
		.cs      (cs)
	);

	ezr_matrix #(
		.OUT_FRAC_BITS (OUT_FRAC_BITS)
	) u_matrix (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (trig_vld),
		.sn      (sn),
		.cs      (cs),
		.vld_out (done),
		.r       (rm)
	);

	assign r00 = rm[0];
	assign r01 = rm[1];
	assign r02 = rm[2];
	assign r10 = rm[3];
	assign r11 = rm[4];
	assign r12 = rm[5];
	assign r20 = rm[6];
	assign r21 = rm[7];
	assign r22 = rm[8];

	`EZR_ASSERT_IMP(a_beat_gives_done, clk, arst_n, beat, ##LAT done)
	`EZR_ASSERT_IMP(a_done_has_beat, clk, arst_n, done, $past(beat, LAT))

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Euler ZYX rotation matrix block. A bit-exact
// fixed-point model predicts all nine elements of every beat. Directed
// corner angles come first, then random in-range and wrapping angles. The
// sender runs in random bursts and gaps.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [8:0][ezr_pkg::OUT_W-1:0] matrix_t;
	typedef logic signed [ezr_pkg::ANG_W-1:0] angle_t;

	localparam int CYCLE_LIMIT = 200000;
	localparam int OFB         = ezr_pkg::OUT_FRAC_BITS_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, busy_s = 1'b1;
	angle_t yaw_deg = '0, pitch_deg = '0, roll_deg = '0;
	logic signed [ezr_pkg::OUT_W-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

	matrix_t expected_mats[$];
	int n_sent = 0, n_checked = 0, n_wrapped = 0, n_errors = 0;
	int cycles = 0;

	euler_zyx_rotation_matrix uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.yaw_deg(yaw_deg), .pitch_deg(pitch_deg), .roll_deg(roll_deg),
		.done(done), .r00(r00), .r01(r01), .r02(r02), .r10(r10), .r11(r11),
		.r12(r12), .r20(r20), .r21(r21), .r22(r22)
	);

	always #5 clk = ~clk;

	always @(negedge clk) busy_s <= busy;

	// quarter-wave sine in Q30, a in [0, QUARTER_UNITS]
	function automatic longint unsigned quarter_sine(longint unsigned a);
		longint unsigned x, x2, t, p, d;
		longint unsigned divs[8];
		divs = '{272, 210, 156, 110, 72, 42, 20, 6};
		x = (a * ezr_pkg::PI_Q30 + ezr_pkg::QUARTER_UNITS) / ezr_pkg::HALF_TURN_UNITS;
		x2 = (x * x + ezr_pkg::HALF_Q30) >> 30;
		t = ezr_pkg::ONE_Q30;
		for (int i = 0; i < 8; i++) begin
			d = divs[i];
			p = (x2 * t + ezr_pkg::HALF_Q30) >> 30;
			t = ezr_pkg::ONE_Q30 - (p + d / 2) / d;
		end
		return (x * t + ezr_pkg::HALF_Q30) >> 30;
	endfunction

	function automatic longint sine_of(int ang);
		int v, q, r;
		longint s;
		v = ang % ezr_pkg::FULL_UNITS;
		if (v < 0) v += ezr_pkg::FULL_UNITS;
		q = v / ezr_pkg::QUARTER_UNITS;
		r = v % ezr_pkg::QUARTER_UNITS;
		s = (q & 1) ? longint'(quarter_sine(ezr_pkg::QUARTER_UNITS - r))
			: longint'(quarter_sine(r));
		return (q >= 2) ? -s : s;
	endfunction

	function automatic longint cosine_of(int ang);
		return sine_of(ang % ezr_pkg::FULL_UNITS + ezr_pkg::QUARTER_UNITS);
	endfunction

	function automatic longint qmul(longint a, longint b);
		longint unsigned ma, mb, m;
		ma = (a < 0) ? -a : a;
		mb = (b < 0) ? -b : b;
		m = (ma * mb + ezr_pkg::HALF_Q30) >> 30;
		return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic [ezr_pkg::OUT_W-1:0] to_element(longint v);
		longint unsigned m;
		longint r;
		int sh;
		sh = ezr_pkg::Q_FRAC - OFB;
		m = (v < 0) ? -v : v;
		if (sh > 0 && sh < 62) m = (m + (64'd1 << (sh - 1))) >> sh;
		if (v < 0) r = (m > ezr_pkg::OUT_NEG_MAX) ? -ezr_pkg::OUT_NEG_MAX : -longint'(m);
		else r = (m > ezr_pkg::OUT_POS_MAX) ? ezr_pkg::OUT_POS_MAX : longint'(m);
		return r[ezr_pkg::OUT_W-1:0];
	endfunction

	function automatic matrix_t rotation_matrix(angle_t yaw, angle_t pitch, angle_t roll);
		longint sz, cz, sy, cy, sx, cx, czsy, szsy;
		matrix_t m;
		sz = sine_of(int'(yaw));   cz = cosine_of(int'(yaw));
		sy = sine_of(int'(pitch)); cy = cosine_of(int'(pitch));
		sx = sine_of(int'(roll));  cx = cosine_of(int'(roll));
		czsy = qmul(cz, sy);
		szsy = qmul(sz, sy);
		m[0] = to_element(qmul(cz, cy));
		m[1] = to_element(qmul(czsy, sx) - qmul(sz, cx));
		m[2] = to_element(qmul(czsy, cx) + qmul(sz, sx));
		m[3] = to_element(qmul(sz, cy));
		m[4] = to_element(qmul(szsy, sx) + qmul(cz, cx));
		m[5] = to_element(qmul(szsy, cx) - qmul(cz, sx));
		m[6] = to_element(-sy);
		m[7] = to_element(qmul(cy, sx));
		m[8] = to_element(qmul(cy, cx));
		return m;
	endfunction

	// drive one beat and hold it until accepted; start stays high afterwards
	task automatic send_angles(angle_t yaw, angle_t pitch, angle_t roll);
		start <= 1'b1;
		yaw_deg <= yaw;
		pitch_deg <= pitch;
		roll_deg <= roll;
		do @(posedge clk); while (busy_s);
		expected_mats.push_back(rotation_matrix(yaw, pitch, roll));
		n_sent++;
		if (yaw > 23040 || yaw < -23040 || pitch > 23040 || pitch < -23040 ||
				roll > 23040 || roll < -23040)
			n_wrapped++;
	endtask

	// a zero-length gap drives nothing, so the next beat follows directly
	task automatic idle_gap(int n);
		if (n > 0) begin
			start <= 1'b0;
			yaw_deg <= angle_t'($urandom);
			pitch_deg <= angle_t'($urandom);
			roll_deg <= angle_t'($urandom);
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic angle_t rand_in_range();
		return angle_t'(int'($urandom_range(46080)) - 23040);
	endfunction

	task automatic test_corners();
		angle_t pts[12];
		pts = '{0, 1, -1, 11520, -11520, 23040, -23040, 5760, 32767, -32768, 23039, 11519};
		for (int i = 0; i < 12; i++) send_angles(pts[i], pts[(i + 5) % 12], pts[(i + 9) % 12]);
		idle_gap(3);
		send_angles(11520, 11520, 11520);
		send_angles(0, 11520, 0);
		send_angles(0, -11520, 5760);
		send_angles(-23040, 23040, -23040);
		send_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_angles(-32768, -32768, -32768);
		send_angles(16'sh5555, -16'sh5556, 16'sh2AAA);
		idle_gap(2);
	endtask

	task automatic run_random(int n_items, int wrap_pct);
		int left, burst;
		left = n_items;
		while (left > 0) begin
			burst = ($urandom_range(3) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
			for (int i = 0; i < burst && left > 0; i++, left--) begin
				if ($urandom_range(99) < wrap_pct)
					send_angles(angle_t'($urandom), angle_t'($urandom), angle_t'($urandom));
				else
					send_angles(rand_in_range(), rand_in_range(), rand_in_range());
			end
			idle_gap($urandom_range(2) == 0 ? 0 : $urandom_range(12, 1));
		end
	endtask

	task automatic test_random_in_range();
		run_random(500, 0);
	endtask

	task automatic test_random_wrapping();
		run_random(250, 60);
	endtask

	// every done beat is compared against the oldest prediction
	always @(posedge clk) begin
		matrix_t got, want;
		if (arst_n && done) begin
			got = {r22, r21, r20, r12, r11, r10, r02, r01, r00};
			if (expected_mats.size() == 0) begin
				n_errors++;
				if (n_errors <= 10) $display("unexpected result beat %h", got);
			end else begin
				want = expected_mats.pop_front();
				n_checked++;
				for (int i = 0; i < 9; i++)
					if (got[i] !== want[i]) begin
						n_errors++;
						if (n_errors <= 10)
							$display("mismatch beat %0d r%0d%0d: expected %0d got %0d",
								n_checked, i / 3, i % 3, $signed(want[i]), $signed(got[i]));
					end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, expected_mats.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corners();
		test_random_in_range();
		test_random_wrapping();
		start <= 1'b0;
		wait (expected_mats.size() == 0);
		repeat (ezr_pkg::EZR_LAT + 10) @(posedge clk);
		$display("%0d angle triples sent, %0d matrices checked, %0d with wrapped angles",
			n_sent, n_checked, n_wrapped);
		$display("%0d element mismatches", n_errors);
		if (n_errors == 0 && expected_mats.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ----- euler_zyx_rotation_matrix.f -----
+incdir+design
design/ezr_pkg.sv
design/ezr_qsin.sv
design/ezr_trig.sv
design/ezr_matrix.sv
design/euler_zyx_rotation_matrix.sv
dv/tb.sv
